### src/matrix_transform_unit_core_defines.svh
// Assertion macros for the matrix transform unit
`ifndef MATRIX_TRANSFORM_UNIT_CORE_DEFINES_SVH
`define MATRIX_TRANSFORM_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MTU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTU_ASSERT_NOW(lbl, ante, cons, msg)
`define MTU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/mtu_pkg.sv
// Shared types, constants and arithmetic helpers of the matrix transform unit
`timescale 1ns / 1ps
package mtu_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE     = 3'd0,
        CMD_READ      = 3'd1,
        CMD_TRANSLATE = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_ROT_X     = 3'd4,
        CMD_ROT_Y     = 3'd5,
        CMD_ROT_Z     = 3'd6,
        CMD_NOP       = 3'd7
    } cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] sin_val;
        logic signed [31:0] cos_val;
    } trig_t;

    localparam logic [31:0]        DEG_FULL     = 32'd23592960;
    localparam logic signed [25:0] DEG_FULL_S   = 26'sd23592960;
    localparam logic signed [25:0] DEG_HALF     = 26'sd11796480;
    localparam logic signed [25:0] DEG_QUARTER  = 26'sd5898240;
    localparam logic signed [27:0] DEG2RAD_Q32  = 28'sd74961320;
    localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;
    localparam logic [4:0]         CORDIC_LAST  = 5'd23;

    function automatic logic signed [32:0] atan_lut(input logic [4:0] i);
        logic signed [32:0] v;
        case (i)
            5'd0:    v = 33'sd843314857;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043837;
            5'd3:    v = 33'sd133525159;
            5'd4:    v = 33'sd67021687;
            5'd5:    v = 33'sd33543516;
            5'd6:    v = 33'sd16775851;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194283;
            5'd9:    v = 33'sd2097149;
            default: v = 33'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rsat64(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [31:0] r;
        t = (p + 64'sd32768) >>> 16;
        if (t > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (t < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = t[31:0];
        return r;
    endfunction

endpackage

### src/mtu_cordic.sv
// Angle reduction and iterative CORDIC sine/cosine in Q16.16
`timescale 1ns / 1ps
module mtu_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output mtu_pkg::trig_t     res
);
    import mtu_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE, C_RED, C_FOLD, C_MUL, C_RAD, C_ITER, C_FIN
    } cstate_t;

    cstate_t            state_reg;
    logic               sgn_reg;
    logic [31:0]        mag_reg;
    logic [2:0]         k_reg;
    logic signed [24:0] m_reg;
    logic               neg_reg;
    logic signed [52:0] prod_reg;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]         i_reg;
    trig_t              res_reg;

    logic [31:0]        full_sh;
    logic signed [25:0] m0, m1, m2;
    logic               fneg;
    logic signed [52:0] rsum, rshift;
    logic signed [32:0] sh_x, sh_y, at;
    logic signed [32:0] cr, sr;

    assign full_sh = DEG_FULL << k_reg;

    always_comb
    begin
        m0 = $signed({1'b0, mag_reg[24:0]});
        if (sgn_reg)
            m0 = -m0;
        m1 = m0;
        if (m0 >= DEG_HALF)
            m1 = m0 - DEG_FULL_S;
        else if (m0 < -DEG_HALF)
            m1 = m0 + DEG_FULL_S;
        m2   = m1;
        fneg = 1'b0;
        if (m1 > DEG_QUARTER)
        begin
            m2   = m1 - DEG_HALF;
            fneg = 1'b1;
        end
        else if (m1 < -DEG_QUARTER)
        begin
            m2   = m1 + DEG_HALF;
            fneg = 1'b1;
        end
    end

    assign rsum   = prod_reg + 53'sd131072;
    assign rshift = rsum >>> 18;
    assign sh_x   = cx_reg >>> i_reg;
    assign sh_y   = cy_reg >>> i_reg;
    assign at     = atan_lut(i_reg);

    always_comb
    begin
        cr = (cx_reg + 33'sd8192) >>> 14;
        sr = (cy_reg + 33'sd8192) >>> 14;
        if (neg_reg)
        begin
            cr = -cr;
            sr = -sr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            sgn_reg   <= 1'b0;
            mag_reg   <= '0;
            k_reg     <= '0;
            m_reg     <= '0;
            neg_reg   <= 1'b0;
            prod_reg  <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            i_reg     <= '0;
            res_reg   <= '0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        sgn_reg   <= angle[31];
                        mag_reg   <= angle[31] ? 32'(-angle) : 32'(angle);
                        k_reg     <= 3'd6;
                        state_reg <= C_RED;
                    end
                end
                C_RED:
                begin
                    if (mag_reg >= full_sh)
                        mag_reg <= mag_reg - full_sh;
                    k_reg <= k_reg - 3'd1;
                    if (k_reg == 3'd0)
                        state_reg <= C_FOLD;
                end
                C_FOLD:
                begin
                    m_reg     <= m2[24:0];
                    neg_reg   <= fneg;
                    state_reg <= C_MUL;
                end
                C_MUL:
                begin
                    prod_reg  <= 53'(m_reg) * 53'(DEG2RAD_Q32);
                    state_reg <= C_RAD;
                end
                C_RAD:
                begin
                    cx_reg    <= CORDIC_GAIN;
                    cy_reg    <= '0;
                    cz_reg    <= rshift[32:0];
                    i_reg     <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - sh_y;
                        cy_reg <= cy_reg + sh_x;
                        cz_reg <= cz_reg - at;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + sh_y;
                        cy_reg <= cy_reg - sh_x;
                        cz_reg <= cz_reg + at;
                    end
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == CORDIC_LAST)
                        state_reg <= C_FIN;
                end
                C_FIN:
                begin
                    res_reg.done    <= 1'b1;
                    res_reg.cos_val <= cr[31:0];
                    res_reg.sin_val <= sr[31:0];
                    state_reg       <= C_IDLE;
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    assign res = res_reg;

endmodule

### src/matrix_transform_unit_core.sv
// Matrix transform unit top level: matrix memory, command sequencer, shared multiplier
// One command at a time. Scale works through nine elements, translate through four columns
// and rotations through the CORDIC sine/cosine and then three columns, all products going
// through the single 32x32 multiplier. The next beat is taken in the cycle after the result
// is registered at the earliest. The matrix sits in a 16-entry memory with one read and
// one write port and a registered read; per-entry valid bits make it read as zero after
// reset. A finished result waits in the output register while the next command is taken.
`timescale 1ns / 1ps
`include "matrix_transform_unit_core_defines.svh"
module matrix_transform_unit_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    input  logic signed [31:0] z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value
);
    import mtu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CORD, S_LOAD, S_MUL, S_WR, S_DONE
    } state_t;

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [3:0]         idx_reg;
    logic signed [31:0] val_reg, x_reg, y_reg, z_reg;
    logic signed [31:0] sin_reg, cos_reg;
    logic [2:0]         k_reg;
    logic [1:0]         r_reg, c_reg;
    logic signed [31:0] e_reg [4];
    logic signed [31:0] q_reg [4];
    logic signed [31:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic               out_valid_reg;
    logic signed [31:0] read_value_reg;

    logic [31:0]        mem [16];
    logic [15:0]        vld_reg;
    logic [31:0]        rdata_reg;
    logic               rvld_reg;
    logic signed [31:0] rdata;

    logic               accept;
    logic               cord_start;
    logic signed [31:0] cord_angle;
    trig_t              cord_res;
    logic [1:0]         ra, rb;
    logic [3:0]         raddr, waddr;
    logic               mem_we;
    logic signed [31:0] wdata;
    logic [2:0]         n_load, n_mul;
    logic signed [31:0] op_a, op_b;
    logic               last_unit;
    logic               out_free;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = state_reg != S_IDLE;
    assign cord_start = accept && (command == CMD_ROT_X || command == CMD_ROT_Y
                                   || command == CMD_ROT_Z);
    assign cord_angle = (command == CMD_ROT_X) ? x : (command == CMD_ROT_Y) ? y : z;
    assign out_free   = !out_valid_reg || !out_stall;

    mtu_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .angle (cord_angle),
        .res   (cord_res)
    );

    always_comb
    begin
        case (cmd_reg)
            CMD_ROT_X: begin ra = 2'd1; rb = 2'd2; end
            CMD_ROT_Y: begin ra = 2'd2; rb = 2'd0; end
            default:   begin ra = 2'd0; rb = 2'd1; end
        endcase
        case (cmd_reg)
            CMD_READ:      begin n_load = 3'd1; n_mul = 3'd0; end
            CMD_TRANSLATE: begin n_load = 3'd4; n_mul = 3'd3; end
            CMD_SCALE:     begin n_load = 3'd1; n_mul = 3'd1; end
            default:       begin n_load = 3'd2; n_mul = 3'd4; end
        endcase
        case (cmd_reg)
            CMD_READ:      raddr = idx_reg;
            CMD_TRANSLATE: raddr = {k_reg[1:0], c_reg};
            CMD_SCALE:     raddr = {r_reg, c_reg};
            default:       raddr = (k_reg == 3'd0) ? {ra, c_reg} : {rb, c_reg};
        endcase
    end

    always_comb
    begin
        op_a = e_reg[0];
        op_b = x_reg;
        case (cmd_reg)
            CMD_TRANSLATE:
            begin
                op_a = e_reg[k_reg[1:0]];
                op_b = (k_reg == 3'd0) ? x_reg : (k_reg == 3'd1) ? y_reg : z_reg;
            end
            CMD_SCALE:
            begin
                op_b = (r_reg == 2'd0) ? x_reg : (r_reg == 2'd1) ? y_reg : z_reg;
            end
            default:
            begin
                op_a = (k_reg == 3'd0 || k_reg == 3'd3) ? e_reg[0] : e_reg[1];
                op_b = (k_reg == 3'd0 || k_reg == 3'd2) ? cos_reg : sin_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = idx_reg;
        wdata  = val_reg;
        if (state_reg == S_WR)
        begin
            case (cmd_reg)
                CMD_WRITE:
                    mem_we = 1'b1;
                CMD_SCALE:
                begin
                    mem_we = 1'b1;
                    waddr  = {r_reg, c_reg};
                    wdata  = q_reg[0];
                end
                CMD_TRANSLATE:
                begin
                    mem_we = k_reg == 3'd2;
                    waddr  = {2'd3, c_reg};
                    wdata  = sat34(34'(e_reg[3]) + 34'(acc_reg));
                end
                CMD_ROT_X, CMD_ROT_Y, CMD_ROT_Z:
                begin
                    mem_we = 1'b1;
                    if (k_reg == 3'd0)
                    begin
                        waddr = {ra, c_reg};
                        wdata = sat34(34'(q_reg[0]) + 34'(q_reg[1]));
                    end
                    else
                    begin
                        waddr = {rb, c_reg};
                        wdata = sat34(34'(q_reg[2]) - 34'(q_reg[3]));
                    end
                end
                default:
                    mem_we = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_TRANSLATE: last_unit = c_reg == 2'd3;
            CMD_SCALE:     last_unit = (c_reg == 2'd2) && (r_reg == 2'd2);
            default:       last_unit = c_reg == 2'd2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[waddr] <= 1'b1;
            rvld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rvld_reg ? $signed(rdata_reg) : 32'sd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_NOP;
            idx_reg        <= '0;
            val_reg        <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            z_reg          <= '0;
            sin_reg        <= '0;
            cos_reg        <= '0;
            k_reg          <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            e_reg          <= '{default: '0};
            q_reg          <= '{default: '0};
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= cmd_t'(command);
                        idx_reg <= element_index;
                        val_reg <= element_value;
                        x_reg   <= x;
                        y_reg   <= y;
                        z_reg   <= z;
                        k_reg   <= '0;
                        r_reg   <= '0;
                        c_reg   <= '0;
                        case (cmd_t'(command))
                            CMD_WRITE:                     state_reg <= S_WR;
                            CMD_READ, CMD_TRANSLATE,
                            CMD_SCALE:                     state_reg <= S_LOAD;
                            CMD_ROT_X, CMD_ROT_Y,
                            CMD_ROT_Z:                     state_reg <= S_CORD;
                            default:                       state_reg <= S_DONE;
                        endcase
                    end
                end
                S_CORD:
                begin
                    if (cord_res.done)
                    begin
                        sin_reg   <= cord_res.sin_val;
                        cos_reg   <= cord_res.cos_val;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (k_reg != 3'd0)
                        e_reg[k_reg[1:0] - 2'd1] <= rdata;
                    if (k_reg == n_load)
                    begin
                        k_reg     <= '0;
                        state_reg <= (cmd_reg == CMD_READ) ? S_DONE : S_MUL;
                    end
                    else
                        k_reg <= k_reg + 3'd1;
                end
                S_MUL:
                begin
                    prod_reg <= 64'(op_a) * 64'(op_b);
                    if (k_reg != 3'd0)
                        q_reg[k_reg[1:0] - 2'd1] <= rsat64(prod_reg);
                    if (k_reg == n_mul)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_WR;
                    end
                    else
                        k_reg <= k_reg + 3'd1;
                end
                S_WR:
                begin
                    if (cmd_reg == CMD_WRITE)
                        state_reg <= S_DONE;
                    else if ((cmd_reg == CMD_TRANSLATE && k_reg != 3'd2) ||
                             ((cmd_reg == CMD_ROT_X || cmd_reg == CMD_ROT_Y ||
                               cmd_reg == CMD_ROT_Z) && k_reg == 3'd0))
                    begin
                        if (k_reg == 3'd0)
                            acc_reg <= sat34(34'(q_reg[0]) + 34'(q_reg[1]));
                        else
                            acc_reg <= sat34(34'(acc_reg) + 34'(q_reg[2]));
                        k_reg <= k_reg + 3'd1;
                    end
                    else
                    begin
                        k_reg <= '0;
                        if (last_unit)
                            state_reg <= S_DONE;
                        else
                        begin
                            state_reg <= S_LOAD;
                            if (cmd_reg == CMD_SCALE && c_reg == 2'd2)
                            begin
                                c_reg <= '0;
                                r_reg <= r_reg + 2'd1;
                            end
                            else
                                c_reg <= c_reg + 2'd1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        read_value_reg <= (cmd_reg == CMD_READ) ? e_reg[0] : 32'sd0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;

    `MTU_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "accepted beat did not start work")
    `MTU_ASSERT_NOW(a_cordic_done_waited, cord_res.done, state_reg == S_CORD, "stray CORDIC result")
    `MTU_ASSERT_NOW(a_no_idle_write, mem_we, state_reg == S_WR, "matrix write outside write phase")
    `MTU_ASSERT_NOW(a_result_held, out_valid_reg && out_stall && state_reg == S_DONE,
        $past(state_reg) == S_DONE || $past(state_reg) == S_LOAD
        || $past(state_reg) == S_WR || $past(state_reg) == S_IDLE, "result stage overrun")

endmodule

### tb/matrix_transform_unit_checker.sv
// Checker for the matrix transform unit: tracks the matrix, predicts each read_value, compares
`timescale 1ns / 1ps
module matrix_transform_unit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         command,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    input  logic signed [31:0] z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] read_value,
    output int                 errors,
    output int                 pending
);
    import mtu_pkg::*;

    localparam longint ANG_FULL = 360 * 65536;
    localparam longint ANG_HALF = 180 * 65536;
    localparam longint ANG_QUARTER = 90 * 65536;
    localparam longint RAD_PER_DEG = 74961320;
    localparam longint GAIN_Q30 = 652032874;

    logic signed [31:0] mat [16];
    logic signed [31:0] read_values [$];
    longint arctan [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return clamp32((a * b + 32768) >>> 16);
    endfunction

    task automatic sine_cosine(longint deg, output longint s, output longint c);
        longint m, ang, cx, cy, cz, nx;
        bit flip;
        m = deg % ANG_FULL;
        flip = 0;
        if (m >= ANG_HALF) m -= ANG_FULL;
        if (m < -ANG_HALF) m += ANG_FULL;
        if (m > ANG_QUARTER)
        begin
            m -= ANG_HALF;
            flip = 1;
        end
        else if (m < -ANG_QUARTER)
        begin
            m += ANG_HALF;
            flip = 1;
        end
        ang = (m * RAD_PER_DEG + (64'sd1 << 17)) >>> 18;
        cx = GAIN_Q30;
        cy = 0;
        cz = ang;
        for (int i = 0; i < 24; i++)
        begin
            if (cz >= 0)
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz -= arctan[i];
            end
            else
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz += arctan[i];
            end
            cx = nx;
        end
        cx = (cx + 8192) >>> 14;
        cy = (cy + 8192) >>> 14;
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        c = cx;
        s = cy;
    endtask

    task automatic turn_rows(int ra, int rb, longint s, longint c);
        longint a, b;
        for (int col = 0; col < 3; col++)
        begin
            a = mat[ra*4+col];
            b = mat[rb*4+col];
            mat[ra*4+col] = 32'(clamp32(fx_mul(a, c) + fx_mul(b, s)));
            mat[rb*4+col] = 32'(clamp32(fx_mul(b, c) - fx_mul(a, s)));
        end
    endtask

    task automatic apply_command(cmd_t op, int idx, longint val, longint px, longint py,
                                 longint pz);
        longint s, c, t;
        logic signed [31:0] res;
        res = '0;
        case (op)
            CMD_WRITE: mat[idx] = 32'(val);
            CMD_READ: res = mat[idx];
            CMD_TRANSLATE:
                for (int col = 0; col < 4; col++)
                begin
                    t = clamp32(fx_mul(mat[col], px) + fx_mul(mat[4+col], py));
                    t = clamp32(t + fx_mul(mat[8+col], pz));
                    mat[12+col] = 32'(clamp32(mat[12+col] + t));
                end
            CMD_SCALE:
                for (int col = 0; col < 3; col++)
                begin
                    mat[col] = 32'(fx_mul(mat[col], px));
                    mat[4+col] = 32'(fx_mul(mat[4+col], py));
                    mat[8+col] = 32'(fx_mul(mat[8+col], pz));
                end
            CMD_ROT_X:
            begin
                sine_cosine(px, s, c);
                turn_rows(1, 2, s, c);
            end
            CMD_ROT_Y:
            begin
                sine_cosine(py, s, c);
                turn_rows(2, 0, s, c);
            end
            CMD_ROT_Z:
            begin
                sine_cosine(pz, s, c);
                turn_rows(0, 1, s, c);
            end
            default: ;
        endcase
        read_values.push_back(res);
    endtask

    assign pending = read_values.size();

    initial
    begin
        errors = 0;
        foreach (mat[i])
            mat[i] = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (read_values.size() == 0)
                begin
                    $error("unexpected result beat, read_value %0d", read_value);
                    errors++;
                end
                else if (read_values[0] !== read_value)
                begin
                    $error("read_value: expected %0d, actual %0d", read_values[0], read_value);
                    errors++;
                    void'(read_values.pop_front());
                end
                else
                    void'(read_values.pop_front());
            end
            if (in_valid && !in_stall)
                apply_command(cmd_t'(command), element_index, element_value, x, y, z);
        end
    end

endmodule

### tb/testbench.sv
// Testbench top: clock, reset, command stimulus, result stalls and verdict
`timescale 1ns / 1ps
module testbench;
    import mtu_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         command;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] read_value;
    int                 errors;
    int                 pending;
    bit                 hold_off;
    int                 quiet;

    matrix_transform_unit_core DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .element_index(element_index),
        .element_value(element_value), .x(x), .y(y), .z(z),
        .out_valid(out_valid), .out_stall(out_stall), .read_value(read_value)
    );

    matrix_transform_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .element_index(element_index),
        .element_value(element_value), .x(x), .y(y), .z(z),
        .out_valid(out_valid), .out_stall(out_stall), .read_value(read_value),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            3, 4: return $signed($urandom_range(0, 'h60000)) - 'h30000;
            5: return $signed($urandom_range(0, 720)) * 65536 - 360 * 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(cmd_t op, logic [3:0] idx, logic [31:0] val, logic [31:0] px,
                        logic [31:0] py, logic [31:0] pz);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        command <= op;
        element_index <= idx;
        element_value <= val;
        x <= px;
        y <= py;
        z <= pz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random();
        int r;
        cmd_t op;
        r = $urandom_range(0, 99);
        if (r < 30) op = CMD_WRITE;
        else if (r < 50) op = CMD_READ;
        else if (r < 60) op = CMD_TRANSLATE;
        else if (r < 68) op = CMD_SCALE;
        else if (r < 76) op = CMD_ROT_X;
        else if (r < 84) op = CMD_ROT_Y;
        else if (r < 92) op = CMD_ROT_Z;
        else op = CMD_NOP;
        send(op, $urandom_range(0, 15), pick_value(), pick_value(), pick_value(),
             pick_value());
    endtask

    initial
    begin
        int wait_cycles;
        out_stall = 0;
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1;
                @(posedge clk);
            end
            else
            begin
                wait_cycles = $urandom_range(0, 16);
                if (wait_cycles != 0)
                begin
                    out_stall <= 1;
                    repeat (wait_cycles) @(posedge clk);
                end
                out_stall <= 0;
                @(posedge clk);
                while (!(out_valid && !out_stall) && !hold_off)
                    @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet <= 0;
        else if (!hold_off)
            quiet <= quiet + 1;
    end

    initial
    begin
        wait (quiet >= IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        command = CMD_NOP;
        element_index = 0;
        element_value = 0;
        x = 0;
        y = 0;
        z = 0;
        hold_off = 0;
        quiet = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int i = 0; i < 16; i++)
            send(CMD_READ, i, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            send(CMD_WRITE, i, (i % 5 == 0) ? 32'h00010000 : 32'h7fffffff - i, 0, 0, 0);
        send(CMD_TRANSLATE, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00010000);
        send(CMD_SCALE, 0, 0, 32'h80000000, 32'h7fffffff, 32'hffff0000);
        send(CMD_ROT_X, 0, 0, 90 << 16, 0, 0);
        send(CMD_ROT_Y, 0, 0, 0, -(180 << 16), 0);
        send(CMD_ROT_Z, 0, 0, 0, 0, 32'h7fffffff);
        send(CMD_ROT_Z, 0, 0, 0, 0, 32'h80000000);
        send(CMD_NOP, 5, 32'h12345678, 1, 2, 3);
        send(CMD_READ, 15, 0, 0, 0, 0);
        fork
        begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
        end
        for (int i = 0; i < 6; i++)
            send_random();
        join
        for (int i = 0; i < 1800; i++)
            send_random();
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
